FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed while running");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/dctle_pkg.sv
`default_nettype none
package dctle_pkg;

  localparam int COEF_WIDTH = 12;
  localparam int MAG_WIDTH  = COEF_WIDTH - 1;
  localparam int POS_WIDTH  = 6;

  localparam logic [1:0] REG_LENGTH_COUNT      = 2'd0;
  localparam logic [1:0] REG_LENGTH_WORD       = 2'd1;
  localparam logic [1:0] REG_LENGTH_START_MASK = 2'd2;
  localparam logic [1:0] REG_PAIR_TOTAL        = 2'd3;

  localparam logic [1:0] CODE_HEADER = 2'd0;
  localparam logic [1:0] CODE_LENGTH = 2'd1;
  localparam logic [1:0] CODE_DATA   = 2'd2;
  localparam logic [1:0] CODE_DONE   = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0]         position;
    logic signed [COEF_WIDTH-1:0] coefficient;
    logic [1:0]                   payload_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coefficient_out;
    logic                         pair_used;
    logic [1:0]                   embed_phase;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  length_count;
    logic [15:0] length_word;
    logic [15:0] length_start_mask;
    logic [15:0] pair_total;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  length_remaining;
    logic [15:0] length_bit_mask;
    logic [15:0] pairs_written;
  } state_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_HEADER: code = CODE_HEADER;
      PH_LENGTH: code = CODE_LENGTH;
      PH_DATA:   code = CODE_DATA;
      PH_DONE:   code = CODE_DONE;
      default:   code = CODE_HEADER;
    endcase
    return code;
  endfunction

  function automatic logic [COEF_WIDTH-1:0] apply_sign(input logic [MAG_WIDTH-1:0] mag,
                                                       input logic neg);
    logic [COEF_WIDTH-1:0] ext;
    ext = {1'b0, mag};
    return neg ? (COEF_WIDTH'(0) - ext) : ext;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dctle_cfg.sv
`default_nettype none
module dctle_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output dctle_pkg::cfg_t  cfg
);

  dctle_pkg::cfg_t cfg_r;
  logic [1:0]      idx;
  logic            wr_en;

  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_count      <= 4'd0;
      cfg_r.length_word       <= 16'd0;
      cfg_r.length_start_mask <= 16'h8000;
      cfg_r.pair_total        <= 16'd0;
    end else if (wr_en) begin
      unique case (idx)
        dctle_pkg::REG_LENGTH_COUNT:      cfg_r.length_count      <= cfg_pwdata[3:0];
        dctle_pkg::REG_LENGTH_WORD:       cfg_r.length_word       <= cfg_pwdata[15:0];
        dctle_pkg::REG_LENGTH_START_MASK: cfg_r.length_start_mask <= cfg_pwdata[15:0];
        dctle_pkg::REG_PAIR_TOTAL:        cfg_r.pair_total        <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dctle_pkg::REG_LENGTH_COUNT:      cfg_prdata = {28'd0, cfg_r.length_count};
      dctle_pkg::REG_LENGTH_WORD:       cfg_prdata = {16'd0, cfg_r.length_word};
      dctle_pkg::REG_LENGTH_START_MASK: cfg_prdata = {16'd0, cfg_r.length_start_mask};
      dctle_pkg::REG_PAIR_TOTAL:        cfg_prdata = {16'd0, cfg_r.pair_total};
      default:                          cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/dctle_embed.sv
`default_nettype none
module dctle_embed (
  input  wire dctle_pkg::in_item_t  item,
  input  wire dctle_pkg::cfg_t      cfg,
  input  wire dctle_pkg::state_t    st,
  output dctle_pkg::out_item_t res,
  output dctle_pkg::state_t    st_nxt
);

  logic [dctle_pkg::COEF_WIDTH-1:0] raw;
  logic [dctle_pkg::COEF_WIDTH-1:0] neg_raw;
  logic [dctle_pkg::COEF_WIDTH-1:0] mag_full;
  logic [dctle_pkg::MAG_WIDTH-1:0]  mag;
  logic                             neg;
  logic                             ac;
  logic                             gt15;
  logic                             gt1;
  logic                             ge4;
  logic                             len_bit;

  assign raw      = item.coefficient;
  assign neg      = raw[dctle_pkg::COEF_WIDTH-1];
  assign neg_raw  = dctle_pkg::COEF_WIDTH'(0) - raw;
  assign mag_full = neg ? neg_raw : raw;
  // most negative value clamps to the largest magnitude
  assign mag      = mag_full[dctle_pkg::COEF_WIDTH-1] ? '1
                                                      : mag_full[dctle_pkg::MAG_WIDTH-1:0];
  assign ac       = item.position != '0;
  assign gt15     = mag[dctle_pkg::MAG_WIDTH-1:4] != '0;
  assign gt1      = mag[dctle_pkg::MAG_WIDTH-1:1] != '0;
  assign ge4      = mag[dctle_pkg::MAG_WIDTH-1:2] != '0;
  assign len_bit  = |(cfg.length_word & st.length_bit_mask);

  always_comb begin
    st_nxt              = st;
    res.coefficient_out = item.coefficient;
    res.pair_used       = 1'b0;
    if (ac) begin
      unique case (st.phase)
        dctle_pkg::PH_HEADER: begin
          if (gt15) begin
            res.coefficient_out = dctle_pkg::apply_sign(
                {mag[dctle_pkg::MAG_WIDTH-1:4], cfg.length_count}, neg);
            st_nxt.length_remaining = {1'b0, cfg.length_count};
            st_nxt.length_bit_mask  = cfg.length_start_mask;
            st_nxt.phase            = dctle_pkg::PH_LENGTH;
          end
        end
        dctle_pkg::PH_LENGTH: begin
          if (gt15) begin
            res.coefficient_out = dctle_pkg::apply_sign(
                {mag[dctle_pkg::MAG_WIDTH-1:1], len_bit}, neg);
            if (st.length_remaining == 5'd0) begin
              st_nxt.phase = dctle_pkg::PH_DATA;
            end
            st_nxt.length_remaining = st.length_remaining - 5'd1;
            st_nxt.length_bit_mask  = {1'b0, st.length_bit_mask[15:1]};
          end
        end
        dctle_pkg::PH_DATA: begin
          if (gt1) begin
            if (ge4) begin
              res.coefficient_out = dctle_pkg::apply_sign(
                  {mag[dctle_pkg::MAG_WIDTH-1:2], item.payload_pair}, neg);
              res.pair_used        = 1'b1;
              st_nxt.pairs_written = st.pairs_written + 16'd1;
            end
            if (st_nxt.pairs_written == cfg.pair_total) begin
              st_nxt.phase = dctle_pkg::PH_DONE;
            end
          end
        end
        dctle_pkg::PH_DONE: ;
        default: ;
      endcase
    end
    res.embed_phase = dctle_pkg::phase_code(st_nxt.phase);
  end

endmodule
`default_nettype wire

FILE: rtl/dct_coefficient_lsb_embedder_core.sv
// DCT coefficient LSB embedder.
// Input channel in_valid/in_ready/in_data carries one quantized coefficient
// with its block position and the next payload pair. Result channel
// out_valid/out_ready/out_data returns exactly one item per input: the
// rewritten coefficient, a flag telling the source a pair was consumed, and
// the embedding phase after that item.
// An accepted item is captured in the output register at the edge that accepts
// it. Throughput is one item per cycle while the receiver does not stall; the
// phase and counter update sits in the same cycle as the embed logic.
// in_ready is high while the output register is empty or being drained, so
// a receiver stall holds the result and stops input after one item.
// Registers on the cfg_ APB port (4 words at byte offsets 0, 4, 8, 12) are to be
// written by the user only while the stream is idle; the block does not enforce it.
// Synchronous reset clears the phase to header, the counters to zero, the
// registers to their defaults and drops out_valid.
`default_nettype none
module dct_coefficient_lsb_embedder_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dctle_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dctle_pkg::out_item_t      out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [3:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic      [31:0]          cfg_prdata,
  output logic                      cfg_pready
);

  dctle_pkg::cfg_t      cfg;
  dctle_pkg::state_t    state_r;
  dctle_pkg::state_t    state_nxt;
  dctle_pkg::out_item_t res;
  dctle_pkg::out_item_t out_data_r;
  logic                 out_valid_r;
  logic                 in_xfer;

  dctle_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dctle_embed u_embed (
    .item   (in_data),
    .cfg    (cfg),
    .st     (state_r),
    .res    (res),
    .st_nxt (state_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= dctle_pkg::PH_HEADER;
      state_r.length_remaining <= 5'd0;
      state_r.length_bit_mask  <= 16'd0;
      state_r.pairs_written    <= 16'd0;
      out_valid_r              <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dctle_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dctle_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire dctle_pkg::out_item_t out_data
);

  logic late_phase;

  assign late_phase = (out_data.embed_phase == dctle_pkg::CODE_DATA) ||
                      (out_data.embed_phase == dctle_pkg::CODE_DONE);

  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)
  `ASSERT_RUN(a_empty_takes_input, clk, rst_n, !out_valid |-> in_ready)
  `ASSERT_RUN(a_pair_in_data_phase, clk, rst_n, (out_valid && out_data.pair_used) |-> late_phase)
  `ASSERT_RUN(a_stall_holds_valid, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `ASSERT_RUN(a_stall_holds_data, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_data))

endmodule

bind dct_coefficient_lsb_embedder_core dctle_checker u_dctle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
